>>> hdl/hsv_to_rgb_converter_defines.svh
// assertion macros for the hsv to rgb converter
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef SYNTH
`define HSV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hsv_to_rgb assertion failed");
`define HSV_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hsv_to_rgb assertion failed");
`else
`define HSV_ASSERT(lbl, clk, rst_n, prop)
`define HSV_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> hdl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

    localparam int NUM_STAGES  = 7;

    localparam int FULL_TURN   = 360;
    localparam int SECTOR_SPAN = 60;
    localparam int FULL_LEVEL  = 255;

    // reciprocal constants, exact over the input ranges
    localparam int HUE_RECIP   = 11651;
    localparam int HUE_SHIFT   = 22;
    localparam int SLOPE_RECIP = 69906;
    localparam int SLOPE_SHIFT = 23;
    localparam int LEVEL_RECIP = 32897;
    localparam int LEVEL_SHIFT = 23;

    localparam int MAX_SLOPE   = 541;

    typedef logic [2:0] t_sector;

    localparam t_sector SEC_R_Y = 3'd0;
    localparam t_sector SEC_Y_G = 3'd1;
    localparam t_sector SEC_G_C = 3'd2;
    localparam t_sector SEC_C_B = 3'd3;
    localparam t_sector SEC_B_M = 3'd4;
    localparam t_sector SEC_M_R = 3'd5;

endpackage

>>> hdl/hsv_to_rgb_converter.sv
// hsv to rgb converter, integer six-sector scheme
//
// input stream: one transaction carries hue (degrees, any 16-bit value,
// taken modulo 360), saturation and brightness. output stream: one
// transaction carries the 8-bit red, green and blue levels for it.
//
// one color is accepted every cycle unless all stages are full and the
// receiver stalls. the pipeline is cut around its multipliers: hue
// reciprocal, slope reciprocal, slope times position and the final
// divide by 255, each followed by a register.
//
// every stage has its own valid bit and loads when it is empty or its
// successor moves, so bubbles are squeezed out. when the receiver stalls
// the result holds at the output and new colors keep entering until all
// seven stages are full; then the input ready drops. nothing is lost or
// repeated.
//
// reset clears all valid bits; data registers are not reset.
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // hue_degrees[15:0], saturation[23:16], brightness[31:24]
    input  logic [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // red_level[7:0], green_level[15:8], blue_level[23:16]
    output logic [23:0] o_m_axis_tdata
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;

    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: hue reciprocal and value products
    logic [15:0] w_hue;
    logic [7:0]  w_sat;
    logic [7:0]  w_val;
    logic [29:0] r1_hue_q;
    logic [15:0] r1_hue;
    logic [15:0] r1_depth;
    logic [15:0] r1_bottom;
    logic [15:0] r1_top;

    assign w_hue = i_s_axis_tdata[15:0];
    assign w_sat = i_s_axis_tdata[23:16];
    assign w_val = i_s_axis_tdata[31:24];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_hue_q  <= 30'(w_hue) * 30'(HUE_RECIP);
            r1_hue    <= w_hue;
            r1_depth  <= 16'(w_val) * 16'(w_sat);
            r1_bottom <= 16'(w_val) * 16'(8'(FULL_LEVEL) - w_sat);
            r1_top    <= 16'(w_val) * 16'(FULL_LEVEL);
        end
    end

    // stage 2: hue modulo 360, slope reciprocal
    logic [7:0]  w2_quo;
    logic [8:0]  r2_h;
    logic [32:0] r2_slope_q;
    logic [14:0] r2_half;
    logic [15:0] r2_bottom;
    logic [15:0] r2_top;

    assign w2_quo = r1_hue_q[HUE_SHIFT +: 8];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_h       <= 9'(r1_hue - 16'(w2_quo) * 16'(FULL_TURN));
            r2_slope_q <= 33'(r1_depth) * 33'(SLOPE_RECIP);
            r2_half    <= r1_depth[15:1];
            r2_bottom  <= r1_bottom;
            r2_top     <= r1_top;
        end
    end

    // stage 3: sector and position
    t_sector     w3_sector;
    t_sector     r3_sector;
    logic [5:0]  r3_pos;
    logic [9:0]  r3_slope;
    logic [14:0] r3_half;
    logic [15:0] r3_bottom;
    logic [15:0] r3_top;

    always_comb begin
        priority if (r2_h >= 9'(5 * SECTOR_SPAN)) begin
            w3_sector = SEC_M_R;
        end else if (r2_h >= 9'(4 * SECTOR_SPAN)) begin
            w3_sector = SEC_B_M;
        end else if (r2_h >= 9'(3 * SECTOR_SPAN)) begin
            w3_sector = SEC_C_B;
        end else if (r2_h >= 9'(2 * SECTOR_SPAN)) begin
            w3_sector = SEC_G_C;
        end else if (r2_h >= 9'(SECTOR_SPAN)) begin
            w3_sector = SEC_Y_G;
        end else begin
            w3_sector = SEC_R_Y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_sector <= w3_sector;
            r3_pos    <= 6'(r2_h - 9'(w3_sector) * 9'(SECTOR_SPAN));
            r3_slope  <= r2_slope_q[SLOPE_SHIFT +: 10];
            r3_half   <= r2_half;
            r3_bottom <= r2_bottom;
            r3_top    <= r2_top;
        end
    end

    // stage 4: rise = slope * pos
    t_sector     r4_sector;
    logic [14:0] r4_rise;
    logic [14:0] r4_half;
    logic [15:0] r4_bottom;
    logic [15:0] r4_top;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_sector <= r3_sector;
            r4_rise   <= 15'(16'(r3_slope) * 16'(r3_pos));
            r4_half   <= r3_half;
            r4_bottom <= r3_bottom;
            r4_top    <= r3_top;
        end
    end

    // stage 5: ramps and channel assignment
    logic [15:0] w5_up_a;
    logic [15:0] w5_up_b;
    logic [15:0] w5_dn_c;
    logic [15:0] w5_dn_d;
    logic [15:0] n5_red;
    logic [15:0] n5_green;
    logic [15:0] n5_blue;
    logic [15:0] r5_red;
    logic [15:0] r5_green;
    logic [15:0] r5_blue;

    assign w5_up_a = r4_bottom + 16'(r4_rise);
    assign w5_up_b = r4_bottom + 16'(r4_half) + 16'(r4_rise);
    assign w5_dn_c = r4_top - 16'(r4_rise);
    assign w5_dn_d = r4_top - 16'(r4_half) - 16'(r4_rise);

    always_comb begin
        unique case (r4_sector)
            SEC_R_Y: begin
                n5_red = w5_dn_c;   n5_green = w5_up_a;   n5_blue = r4_bottom;
            end
            SEC_Y_G: begin
                n5_red = w5_dn_d;   n5_green = w5_up_b;   n5_blue = r4_bottom;
            end
            SEC_G_C: begin
                n5_red = r4_bottom; n5_green = w5_dn_c;   n5_blue = w5_up_a;
            end
            SEC_C_B: begin
                n5_red = r4_bottom; n5_green = w5_dn_d;   n5_blue = w5_up_b;
            end
            SEC_B_M: begin
                n5_red = w5_up_a;   n5_green = r4_bottom; n5_blue = w5_dn_c;
            end
            default: begin
                n5_red = w5_up_b;   n5_green = r4_bottom; n5_blue = w5_dn_d;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_red   <= n5_red;
            r5_green <= n5_green;
            r5_blue  <= n5_blue;
        end
    end

    // stage 6: divide by 255 through reciprocal
    logic [31:0] r6_red_q;
    logic [31:0] r6_green_q;
    logic [31:0] r6_blue_q;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_red_q   <= 32'(r5_red) * 32'(LEVEL_RECIP);
            r6_green_q <= 32'(r5_green) * 32'(LEVEL_RECIP);
            r6_blue_q  <= 32'(r5_blue) * 32'(LEVEL_RECIP);
        end
    end

    // stage 7: output register
    logic [7:0] r7_red;
    logic [7:0] r7_green;
    logic [7:0] r7_blue;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r7_red   <= r6_red_q[LEVEL_SHIFT +: 8];
            r7_green <= r6_green_q[LEVEL_SHIFT +: 8];
            r7_blue  <= r6_blue_q[LEVEL_SHIFT +: 8];
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[NUM_STAGES-1];
    assign o_m_axis_tdata  = {r7_blue, r7_green, r7_red};

    `HSV_ASSERT(a_full_when_blocked, i_clk, i_rst_n,
        !o_s_axis_tready |-> (&r_vld && !i_m_axis_tready))
    `HSV_ASSERT(a_accept_lands, i_clk, i_rst_n,
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
    `HSV_ASSERT(a_slope_range, i_clk, i_rst_n,
        r_vld[2] |-> (r3_slope <= 10'(MAX_SLOPE) && r3_pos < 6'(SECTOR_SPAN)))
    `HSV_ASSERT(a_stall_holds_out, i_clk, i_rst_n,
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(r7_red)))

endmodule
